[rtl/signed_int_to_decimal_ascii_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decimal ASCII converter
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication.
`define SITDA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SITDA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Constants and the job record passed from the converter to the serializer.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int MAX_DEST         = 64;
    localparam int SMALL_DEST_LIMIT = 22;
    localparam int NDIG             = 19;   // enough for 2^63

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [NDIG-1:0][3:0] digits;      // BCD, digit 0 least significant
        logic                 lead_minus;  // '-' as first character
        logic                 mid_minus;   // '-' between padding and digits
        logic [6:0]           pad_cnt;
        logic [7:0]           pad_byte;
        logic [6:0]           len;         // characters including terminator
        logic                 fits;
    } job_t;

endpackage

[rtl/sitda_if.sv]
// ----------------------------------------------------------------------------
// sitda_if
// Request and response channels of the decimal ASCII converter.
// ----------------------------------------------------------------------------
interface sitda_req_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic        [7:0]  width_req;
    logic        [7:0]  pad_byte;
    logic        [6:0]  dest_size;

    modport source (output valid, output value, output width_req, output pad_byte,
                    output dest_size, input ready);
    modport sink   (input valid, input value, input width_req, input pad_byte,
                    input dest_size, output ready);
endinterface

interface sitda_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_char;
    logic [6:0] char_count;
    logic       fits;

    modport source (output valid, output char_out, output last_char,
                    output char_count, output fits, input ready);
    modport sink   (input valid, input char_out, input last_char,
                    input char_count, input fits, output ready);
endinterface

[rtl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 64-bit integer to padded, zero-terminated decimal ASCII text.
//
// req carries value, width_req, pad_byte and dest_size; rsp returns the
// characters of each request, most significant first, ending with a zero
// terminator flagged by last_char. A destination that is too small gives a
// single zero character with fits low and last_char high.
// The converter captures a request, converts it to BCD (4 bits per cycle),
// counts the digits and hands the job to a QUEUE_DEPTH-entry queue; it
// takes no new request until that job is handed over. The serializer loads
// a job, then emits one character per cycle while the receiver is ready.
// The two halves overlap across the queue.
// Reset empties the queue and output register; no clearing pass is needed.
// A stalled receiver holds the output register; the converter keeps working
// until the queue fills, then waits to hand over the job with req.ready low.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    sitda_req_if.sink   req,
    sitda_rsp_if.source rsp
);
    import sitda_pkg::*;

    logic f_valid, f_ready;
    job_t f_job;
    logic b_valid, b_ready;
    job_t b_job;

    sitda_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    sitda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_job    (b_job)
    );

    sitda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .rsp       (rsp)
    );

    `SITDA_ASSERT_NOW(a_fail_single, rsp.valid && !rsp.fits, rsp.last_char && (rsp.char_out == CH_NUL), "failed fit must be a single zero item")
    `SITDA_ASSERT_NOW(a_last_is_nul, rsp.valid && rsp.last_char, rsp.char_out == CH_NUL, "last character must be the terminator")
    `SITDA_ASSERT_NEXT(a_run_unbroken, rsp.valid && rsp.ready && !rsp.last_char, rsp.valid && (rsp.char_count == $past(rsp.char_count)), "string run broken or count changed")

endmodule

[rtl/sitda_front.sv]
// ----------------------------------------------------------------------------
// sitda_front
// Accepts a request, converts the magnitude to BCD four bits per cycle
// (double dabble) and works out sign placement, padding and length.
// ----------------------------------------------------------------------------
module sitda_front (
    input  logic          clk,
    input  logic          rst_n,
    sitda_req_if.sink     req,
    output logic          job_valid,
    input  logic          job_ready,
    output sitda_pkg::job_t job
);
    import sitda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_LEN  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [63:0]       mag_reg, mag_next;
    logic [NDIG*4-1:0] bcd_reg, bcd_next;
    logic              neg_reg, neg_next;
    logic [7:0]        width_reg, width_next;
    logic [7:0]        pad_reg, pad_next;
    logic [6:0]        dest_reg, dest_next;
    logic [4:0]        ndig_reg, ndig_next;

    logic [NDIG*4-1:0] bcd_step;
    logic [63:0]       mag_step;
    logic [4:0]        ndig_c;

    // length arithmetic
    logic       wnz, zero_pad, add_mid, gt, mbp;
    logic [7:0] total0, t1, wid, npad, t2, total;

    // four double-dabble iterations
    always_comb
    begin
        bcd_step = bcd_reg;
        mag_step = mag_reg;
        for (int s = 0; s < 4; s++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (bcd_step[d*4 +: 4] >= 4'd5)
                    bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
            bcd_step = {bcd_step[NDIG*4-2:0], mag_step[63]};
            mag_step = {mag_step[62:0], 1'b0};
        end
    end

    always_comb
    begin
        ndig_c = 5'd1;
        for (int d = 1; d < NDIG; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
                ndig_c = 5'(d + 1);
        end
    end

    always_comb
    begin
        wnz      = (width_reg != 8'd0);
        zero_pad = (pad_reg == CH_ZERO);
        add_mid  = neg_reg && !zero_pad && wnz;
        total0   = {3'b0, ndig_reg} + 8'd1;
        t1       = total0 + {7'b0, add_mid};
        wid      = (width_reg > {1'b0, dest_reg}) ? {1'b0, dest_reg} : width_reg;
        gt       = wnz && (wid > t1);
        npad     = gt ? (wid - t1) : 8'd0;
        t2       = t1 + npad;
        mbp      = neg_reg && (!wnz || (zero_pad && npad == 8'd0));
        total    = t2 + {7'b0, mbp};

        job.digits     = bcd_reg;
        job.lead_minus = neg_reg && (!wnz || zero_pad);
        job.mid_minus  = add_mid;
        // with '0' padding the sign takes the place of the first pad
        job.pad_cnt    = (neg_reg && zero_pad && npad != 8'd0) ? 7'(npad - 8'd1)
                                                               : npad[6:0];
        job.pad_byte   = pad_reg;
        job.len        = total[6:0];
        job.fits       = !((dest_reg < 7'(SMALL_DEST_LIMIT)) &&
                           (total > {1'b0, dest_reg}));
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign job_valid = (state_reg == ST_PUSH);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        width_next = width_reg;
        pad_next   = pad_reg;
        dest_next  = dest_reg;
        ndig_next  = ndig_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    neg_next   = req.value[63];
                    mag_next   = req.value[63] ? (~req.value + 64'd1) : req.value;
                    bcd_next   = '0;
                    cnt_next   = 4'd0;
                    width_next = req.width_req;
                    pad_next   = req.pad_byte;
                    dest_next  = (req.dest_size > 7'(MAX_DEST)) ? 7'(MAX_DEST)
                                                                : req.dest_size;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = bcd_step;
                mag_next = mag_step;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                ndig_next  = ndig_c;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (job_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        width_reg <= width_next;
        pad_reg   <= pad_next;
        dest_reg  <= dest_next;
        ndig_reg  <= ndig_next;
    end

endmodule

[rtl/sitda_queue.sv]
// ----------------------------------------------------------------------------
// sitda_queue
// Small FIFO of finished jobs between converter and serializer.
// ----------------------------------------------------------------------------
module sitda_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  sitda_pkg::job_t push_job,
    output logic            pop_valid,
    input  logic            pop_ready,
    output sitda_pkg::job_t pop_job
);
    import sitda_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = entry_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push_job;
    end

endmodule

[rtl/sitda_back.sv]
// ----------------------------------------------------------------------------
// sitda_back
// Serializes one job into characters through a registered output stage.
// ----------------------------------------------------------------------------
module sitda_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  sitda_pkg::job_t job,
    sitda_rsp_if.source     rsp
);
    import sitda_pkg::*;

    logic       busy_reg, busy_next;
    logic [6:0] pos_reg, pos_next;
    job_t       job_reg;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic [6:0] out_count_reg;
    logic       out_fits_reg;

    logic       advance, is_last;
    logic [6:0] pad_start, mid_start, dig_start, dig_idx;
    logic [7:0] ch;

    assign job_ready = !busy_reg;
    assign advance   = busy_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        pad_start = {6'b0, job_reg.lead_minus};
        mid_start = pad_start + job_reg.pad_cnt;
        dig_start = mid_start + {6'b0, job_reg.mid_minus};
        dig_idx   = job_reg.len - 7'd2 - pos_reg;   // most significant first
        is_last   = !job_reg.fits || (pos_reg == job_reg.len - 7'd1);
        if (!job_reg.fits || is_last)
            ch = CH_NUL;
        else if (pos_reg < pad_start)
            ch = CH_MINUS;
        else if (pos_reg < mid_start)
            ch = job_reg.pad_byte;
        else if (pos_reg < dig_start)
            ch = CH_MINUS;
        else
            ch = CH_ZERO | {4'b0, job_reg.digits[dig_idx[4:0]]};
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (!busy_reg && job_valid)
        begin
            busy_next = 1'b1;
            pos_next  = 7'd0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            pos_next       = pos_reg + 7'd1;
            if (is_last)
                busy_next = 1'b0;
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && job_valid)
            job_reg <= job;
        if (advance)
        begin
            out_char_reg  <= ch;
            out_last_reg  <= is_last;
            out_count_reg <= job_reg.len;
            out_fits_reg  <= job_reg.fits;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.char_out   = out_char_reg;
    assign rsp.last_char  = out_last_reg;
    assign rsp.char_count = out_count_reg;
    assign rsp.fits       = out_fits_reg;

endmodule

[tb/tb_signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Self-checking bench for the signed 64-bit to decimal ASCII converter.
// A driver feeds requests from a queue and predicts the character stream of
// each one. A monitor checks every returned character against that stream.
// Both sides insert random idle cycles, with occasional back-to-back runs.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    import sitda_pkg::*;

    typedef struct packed {
        logic signed [63:0] value;
        logic        [7:0]  width;
        logic        [7:0]  pad;
        logic        [6:0]  dest;
    } conv_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
        logic [6:0] count;
        logic       fits;
    } char_rec_t;

    localparam int RANDOM_REQS = 195;
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n;

    sitda_req_if req_ch ();
    sitda_rsp_if rsp_ch ();

    signed_int_to_decimal_ascii dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    conv_req_t pending_reqs [$];
    char_rec_t char_expect [$];
    conv_req_t cur_req;

    int send_wait;
    int send_calm;
    int recv_wait;
    int recv_calm;

    int mismatch_count;
    int reqs_sent;
    int chars_checked;
    int no_fit_count;
    int padded_count;
    int negative_count;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle cycles before the next transfer; sometimes a stretch of zero waits.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic conv_req_t mk_req(logic signed [63:0] value, logic [7:0] width,
                                         logic [7:0] pad, logic [6:0] dest);
        conv_req_t r;
        r.value = value;
        r.width = width;
        r.pad   = pad;
        r.dest  = dest;
        return r;
    endfunction

    function automatic conv_req_t random_request();
        conv_req_t r;
        logic [63:0] raw;
        int nbits;
        int sel;
        raw = {$urandom, $urandom};
        nbits = $urandom_range(0, 64);
        if (nbits < 64)
            raw &= (64'd1 << nbits) - 64'd1;
        if ($urandom_range(0, 1) == 1)
            raw = -raw;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            raw = 64'h8000_0000_0000_0000;
        else if (sel == 1)
            raw = 64'h7FFF_FFFF_FFFF_FFFF;
        r.value = raw;

        sel = $urandom_range(0, 9);
        if (sel < 3)
            r.width = 8'd0;
        else if (sel < 8)
            r.width = 8'($urandom_range(1, 30));
        else
            r.width = 8'($urandom_range(0, 255));

        sel = $urandom_range(0, 19);
        if (sel < 7)
            r.pad = CH_ZERO;
        else if (sel < 12)
            r.pad = 8'h20;
        else
            r.pad = 8'($urandom_range(0, 255));

        sel = $urandom_range(0, 19);
        if (sel < 10)
            r.dest = 7'($urandom_range(SMALL_DEST_LIMIT, MAX_DEST));
        else if (sel < 17)
            r.dest = 7'($urandom_range(0, SMALL_DEST_LIMIT - 1));
        else
            r.dest = 7'($urandom_range(MAX_DEST + 1, 127));
        return r;
    endfunction

    // Builds the padded decimal string of one request and queues its characters.
    function automatic void predict_text(conv_req_t r);
        logic [7:0] rev_dig [0:19];
        logic [7:0] text [$];
        logic [63:0] mag;
        logic neg;
        logic zero_pad;
        logic lead_minus;
        int ndig;
        int total;
        int npad;
        int wid;
        int dest;
        int w;
        char_rec_t rec;

        neg = r.value[63];
        mag = neg ? (~r.value + 64'd1) : r.value;
        w = r.width;
        zero_pad = (r.pad == CH_ZERO);
        dest = (r.dest > MAX_DEST) ? MAX_DEST : r.dest;
        if (neg)
            negative_count++;

        ndig = 0;
        do
        begin
            rev_dig[ndig] = 8'(CH_ZERO + 8'(mag % 64'd10));
            ndig++;
            mag = mag / 64'd10;
        end
        while (mag != 64'd0);

        total = ndig + 1;
        npad = 0;
        lead_minus = 1'b0;
        if (w != 0)
        begin
            if (neg && !zero_pad)
                total++;
            wid = (w > dest) ? dest : w;
            if (wid > total)
            begin
                npad = wid - total;
                total = wid;
            end
            if (neg && zero_pad && npad == 0)
            begin
                lead_minus = 1'b1;
                total++;
            end
        end
        else if (neg)
        begin
            lead_minus = 1'b1;
            total++;
        end

        if (dest < SMALL_DEST_LIMIT && total > dest)
        begin
            rec.ch      = CH_NUL;
            rec.is_last = 1'b1;
            rec.count   = 7'(total);
            rec.fits    = 1'b0;
            char_expect.push_back(rec);
            no_fit_count++;
            return;
        end

        if (npad != 0)
            padded_count++;
        if (lead_minus)
            text.push_back(CH_MINUS);
        for (int i = 0; i < npad; i++)
            text.push_back(r.pad);
        // zero padding: the sign overwrites the leftmost pad; otherwise it follows the padding
        if (neg && w != 0)
        begin
            if (zero_pad)
            begin
                if (npad != 0)
                    text[0] = CH_MINUS;
            end
            else
                text.push_back(CH_MINUS);
        end
        for (int i = ndig - 1; i >= 0; i--)
            text.push_back(rev_dig[i]);
        text.push_back(CH_NUL);

        for (int i = 0; i < text.size(); i++)
        begin
            rec.ch      = text[i];
            rec.is_last = (i == text.size() - 1);
            rec.count   = 7'(text.size());
            rec.fits    = 1'b1;
            char_expect.push_back(rec);
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR @%0t ns: %s", $time, msg);
    endtask

    task automatic check_char();
        char_rec_t want;
        if (char_expect.size() == 0)
        begin
            flag_mismatch($sformatf("character 0x%02h with nothing outstanding",
                                    rsp_ch.char_out));
            return;
        end
        want = char_expect.pop_front();
        chars_checked++;
        if (rsp_ch.char_out !== want.ch)
            flag_mismatch($sformatf("char_out 0x%02h, want 0x%02h",
                                    rsp_ch.char_out, want.ch));
        if (rsp_ch.last_char !== want.is_last)
            flag_mismatch($sformatf("last_char %b, want %b",
                                    rsp_ch.last_char, want.is_last));
        if (rsp_ch.char_count !== want.count)
            flag_mismatch($sformatf("char_count %0d, want %0d",
                                    rsp_ch.char_count, want.count));
        if (rsp_ch.fits !== want.fits)
            flag_mismatch($sformatf("fits %b, want %b", rsp_ch.fits, want.fits));
    endtask

    // Request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_text(cur_req);
                reqs_sent++;
                send_wait = draw_wait(send_calm);
            end
            else if (!req_ch.valid && send_wait > 0)
                send_wait--;

            if ((!req_ch.valid || req_ch.ready) && send_wait == 0 &&
                pending_reqs.size() != 0)
            begin
                cur_req = pending_reqs.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.value     <= cur_req.value;
                req_ch.width_req <= cur_req.width;
                req_ch.pad_byte  <= cur_req.pad;
                req_ch.dest_size <= cur_req.dest;
            end
            else if (req_ch.valid && req_ch.ready)
                req_ch.valid <= 1'b0;
        end
    end

    // Character monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                check_char();
                recv_wait = draw_wait(recv_calm);
            end
            else if (!rsp_ch.ready && recv_wait > 0)
                recv_wait--;
            rsp_ch.ready <= (recv_wait == 0);
        end
    end

    initial
    begin
        #3ms;
        $display("timeout: %0d characters still outstanding", char_expect.size());
        $display("signed_int_to_decimal_ascii: mismatch");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.value     = '0;
        req_ch.width_req = '0;
        req_ch.pad_byte  = '0;
        req_ch.dest_size = '0;
        rsp_ch.ready     = 1'b0;
        send_wait = 0;
        send_calm = 0;
        recv_wait = 0;
        recv_calm = 0;
        mismatch_count = 0;
        reqs_sent = 0;
        chars_checked = 0;
        no_fit_count = 0;
        padded_count = 0;
        negative_count = 0;

        // directed corners
        pending_reqs.push_back(mk_req(64'sd0, 8'd0, 8'h20, 7'd64));
        pending_reqs.push_back(mk_req(64'sd1, 8'd0, 8'h20, 7'd64));
        pending_reqs.push_back(mk_req(-64'sd1, 8'd0, 8'h20, 7'd64));
        pending_reqs.push_back(mk_req(64'sh7FFF_FFFF_FFFF_FFFF, 8'd0, 8'h20, 7'd64));
        pending_reqs.push_back(mk_req(64'sh8000_0000_0000_0000, 8'd0, 8'h20, 7'd64));
        pending_reqs.push_back(mk_req(64'sh8000_0000_0000_0000, 8'd0, CH_ZERO, 7'd21));
        pending_reqs.push_back(mk_req(64'sh8000_0000_0000_0000, 8'd0, 8'h20, 7'd20));
        pending_reqs.push_back(mk_req(-64'sd42, 8'd10, 8'h20, 7'd64));
        pending_reqs.push_back(mk_req(-64'sd42, 8'd10, CH_ZERO, 7'd64));
        pending_reqs.push_back(mk_req(-64'sd42, 8'd3, CH_ZERO, 7'd64));
        pending_reqs.push_back(mk_req(-64'sd42, 8'd4, CH_ZERO, 7'd64));
        pending_reqs.push_back(mk_req(64'sd42, 8'd3, 8'h20, 7'd64));
        pending_reqs.push_back(mk_req(64'sd42, 8'd255, 8'h2A, 7'd64));
        pending_reqs.push_back(mk_req(-64'sd7, 8'd255, CH_ZERO, 7'd127));
        pending_reqs.push_back(mk_req(64'sd5, 8'd200, 8'hFF, 7'd10));
        pending_reqs.push_back(mk_req(64'sd123, 8'd0, 8'h20, 7'd0));
        pending_reqs.push_back(mk_req(64'sd123, 8'd0, 8'h20, 7'd4));
        pending_reqs.push_back(mk_req(64'sd123, 8'd0, 8'h20, 7'd3));
        pending_reqs.push_back(mk_req(64'sd123, 8'd30, 8'h20, 7'd21));
        pending_reqs.push_back(mk_req(-64'sd123, 8'd30, 8'h20, 7'd22));
        pending_reqs.push_back(mk_req(64'sh7FFF_FFFF_FFFF_FFFF, 8'd0, 8'h20, 7'd19));
        pending_reqs.push_back(mk_req(64'sd0, 8'd1, 8'h00, 7'd64));
        pending_reqs.push_back(mk_req(64'sd0, 8'd5, 8'h00, 7'd64));
        pending_reqs.push_back(mk_req(-64'sd5, 8'd0, CH_ZERO, 7'd1));
        pending_reqs.push_back(mk_req(64'sd9, 8'd0, 8'h20, 7'd127));

        for (int i = 0; i < RANDOM_REQS; i++)
            pending_reqs.push_back(random_request());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (char_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (char_expect.size() != 0)
            flag_mismatch($sformatf("%0d characters never arrived", char_expect.size()));

        $display("covered %0d requests (%0d negative, %0d padded, %0d too small)",
                 reqs_sent, negative_count, padded_count, no_fit_count);
        $display("checked %0d characters, %0d errors", chars_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("signed_int_to_decimal_ascii: match");
        else
            $display("signed_int_to_decimal_ascii: mismatch");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/sitda_pkg.sv
rtl/sitda_if.sv
rtl/sitda_front.sv
rtl/sitda_queue.sv
rtl/sitda_back.sv
rtl/signed_int_to_decimal_ascii.sv
tb/tb_signed_int_to_decimal_ascii.sv
